// ===== sv/mpcs_pkg.sv =====
// Shared types and register index codes for the motor PWM command shaper.
package mpcs_pkg;

  localparam int NUM_CH_REGS = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CMD_W       = 16;
  localparam int MAXD_W      = 15;
  localparam int DUTY_W      = 12;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY_CH0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY_CH1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY_CH2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND_CH2      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SIGN_MASK = 3'd6;

  typedef struct packed {
    logic [NUM_CH_REGS-1:0][MAXD_W-1:0] max_duty;
    logic [NUM_CH_REGS-1:0][CMD_W-1:0]  deadband;
    logic [NUM_CH_REGS-1:0]             forward_sign_mask;
  } cfg_t;

  // One word in flight between pipeline stages.
  typedef struct packed {
    logic              valid;
    logic [1:0]        channel;
    logic              neg;
    logic              pos;
    logic [CMD_W-1:0]  mag;
    logic [MAXD_W-1:0] pmax;
    logic [CMD_W-1:0]  deadband;
  } stage_t;

endpackage

// ===== sv/mpcs_front.sv =====
// First stage: register lookup, end-of-travel zeroing and magnitude.
module mpcs_front #(
  parameter int CHANNELS = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  channel,
  input  logic signed [mpcs_pkg::CMD_W-1:0] command,
  input  logic                        at_lower_limit,
  input  logic                        at_upper_limit,
  input  mpcs_pkg::cfg_t              cfg,
  output mpcs_pkg::stage_t            q
);

  logic                         ch_ok;
  logic [mpcs_pkg::MAXD_W-1:0]  pmax;
  logic [mpcs_pkg::CMD_W-1:0]   db;
  logic                         fwd;
  logic                         neg;
  logic                         pos;
  logic                         kill;
  logic [mpcs_pkg::CMD_W-1:0]   mag;

  always_comb begin
    ch_ok = (int'(channel) < CHANNELS);
    pmax  = '0;
    db    = '0;
    fwd   = 1'b0;
    case (channel)
      2'd0: begin
        pmax = cfg.max_duty[0];
        db   = cfg.deadband[0];
        fwd  = cfg.forward_sign_mask[0];
      end
      2'd1: begin
        pmax = cfg.max_duty[1];
        db   = cfg.deadband[1];
        fwd  = cfg.forward_sign_mask[1];
      end
      2'd2: begin
        pmax = cfg.max_duty[2];
        db   = cfg.deadband[2];
        fwd  = cfg.forward_sign_mask[2];
      end
      default: begin
        pmax = '0;
      end
    endcase
    if (!ch_ok) begin
      pmax = '0;
      db   = '0;
      fwd  = 1'b0;
    end
    neg  = command[mpcs_pkg::CMD_W-1];
    pos  = !neg && (command != '0);
    // Drop any command that pushes further into an end stop.
    kill = (at_lower_limit && ((neg && fwd) || (pos && !fwd))) ||
           (at_upper_limit && ((pos && fwd) || (neg && !fwd)));
    if (kill) begin
      mag = '0;
    end else if (neg) begin
      mag = mpcs_pkg::CMD_W'(-command);
    end else begin
      mag = mpcs_pkg::CMD_W'(command);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= accept;
    end
    q.channel  <= channel;
    q.neg      <= neg;
    q.pos      <= pos;
    q.mag      <= mag;
    q.pmax     <= pmax;
    q.deadband <= db;
  end

endmodule

// ===== sv/mpcs_deadband.sv =====
// Second stage: deadband threshold or offset on the magnitude.
module mpcs_deadband (
  input  logic             clk,
  input  logic             rst,
  input  mpcs_pkg::stage_t d,
  output mpcs_pkg::stage_t q
);

  logic signed [mpcs_pkg::CMD_W:0] db_ext;
  logic [mpcs_pkg::CMD_W:0]        thr;
  logic [mpcs_pkg::CMD_W-1:0]      mag;

  always_comb begin
    db_ext = {d.deadband[mpcs_pkg::CMD_W-1], d.deadband};
    thr    = (mpcs_pkg::CMD_W+1)'(-db_ext);
    mag    = d.mag;
    if (d.mag != '0) begin
      if (db_ext < 0) begin
        if ({1'b0, d.mag} < thr) begin
          mag = '0;
        end
      end else begin
        // Both terms stay below 2^15 plus one, so the sum fits.
        mag = d.mag + d.deadband;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.channel  <= d.channel;
    q.neg      <= d.neg;
    q.pos      <= d.pos;
    q.mag      <= mag;
    q.pmax     <= d.pmax;
    q.deadband <= d.deadband;
  end

endmodule

// ===== sv/mpcs_clamp.sv =====
// Third stage: duty clamping, inversion and reported command.
module mpcs_clamp #(
  parameter int FULL_DUTY = 4095,
  parameter int MIN_DUTY  = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mpcs_pkg::stage_t                  d,
  output logic                              done,
  output logic [1:0]                        out_channel,
  output logic [mpcs_pkg::DUTY_W-1:0]       duty,
  output logic                              direction,
  output logic signed [mpcs_pkg::CMD_W-1:0] reported_command
);

  localparam int AW = mpcs_pkg::CMD_W + 2;
  localparam logic signed [AW-1:0] FULL_S = AW'(FULL_DUTY);
  localparam logic signed [AW-1:0] MIN_S  = AW'(MIN_DUTY);

  logic signed [AW-1:0]       mag_s;
  logic signed [AW-1:0]       pmax_s;
  logic signed [AW-1:0]       pm;
  logic signed [AW-1:0]       x;
  logic signed [AW-1:0]       lo;
  logic signed [AW-1:0]       hi;
  logic signed [AW-1:0]       duty_s;
  logic [mpcs_pkg::CMD_W-1:0] rep_mag;
  logic [mpcs_pkg::CMD_W-1:0] rep;

  always_comb begin
    mag_s  = AW'({2'b00, d.mag});
    pmax_s = AW'({3'b000, d.pmax});
    pm     = (pmax_s < FULL_S) ? pmax_s : FULL_S;
    if (pm < MIN_S) begin
      pm = MIN_S;
    end
    if (d.neg) begin
      x  = FULL_S - mag_s;
      lo = FULL_S - pm;
      hi = FULL_S - MIN_S;
    end else begin
      x  = mag_s;
      lo = MIN_S;
      hi = pm;
    end
    if (x < lo) begin
      duty_s = lo;
    end else if (x > hi) begin
      duty_s = hi;
    end else begin
      duty_s = x;
    end
    rep_mag = (d.mag > {1'b0, d.pmax}) ? {1'b0, d.pmax} : d.mag;
    if (d.neg) begin
      rep = -rep_mag;
    end else if (d.pos) begin
      rep = rep_mag;
    end else begin
      rep = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d.valid;
    end
    out_channel      <= d.channel;
    duty             <= duty_s[mpcs_pkg::DUTY_W-1:0];
    direction        <= !d.pos;
    reported_command <= rep;
  end

endmodule

// ===== sv/motor_pwm_command_shaper.sv =====
// Top level of the motor PWM command shaper: configuration registers and pipeline.
//
// Usage: raise start with channel, command and the two end-of-travel flags;
// the word is taken at any rising edge where start is high and busy is low.
// busy is high only while rst is held, so a new word can be issued on every
// cycle. Each word yields exactly one result, shown for one cycle with done
// high, once it has passed three registered stages: the front stage looks up the
// channel registers and zeroes commands pushing into an end stop, the second
// stage applies the deadband, and the third clamps the duty and forms the
// reported command. The rate is one word per cycle, set by the three
// registered stages, each of which takes a new word every clock.
//
// Configuration goes through its own write channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Index 0-2 sets the channel
// maximum duty, 3-5 the deadband, 6 the forward-sign mask; index 7 is
// ignored. Write registers only when no words are in flight.
//
// Reset (rst, synchronous) clears the configuration registers to zero and empties the
// pipeline. The receiver cannot stall: results must be taken as they appear.
module motor_pwm_command_shaper #(
  parameter int FULL_DUTY = 4095,
  parameter int MIN_DUTY  = 0,
  parameter int CHANNELS  = 3
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             channel,
  input  logic signed [mpcs_pkg::CMD_W-1:0]      command,
  input  logic                                   at_lower_limit,
  input  logic                                   at_upper_limit,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mpcs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mpcs_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   done,
  output logic [1:0]                             out_channel,
  output logic [mpcs_pkg::DUTY_W-1:0]            duty,
  output logic                                   direction,
  output logic signed [mpcs_pkg::CMD_W-1:0]      reported_command
);

  mpcs_pkg::cfg_t   cfg;
  mpcs_pkg::stage_t s1;
  mpcs_pkg::stage_t s2;
  logic             accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Register file; writes beyond the last index fall through untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpcs_pkg::REG_MAX_DUTY_CH0: cfg.max_duty[0] <= cfg_data[mpcs_pkg::MAXD_W-1:0];
        mpcs_pkg::REG_MAX_DUTY_CH1: cfg.max_duty[1] <= cfg_data[mpcs_pkg::MAXD_W-1:0];
        mpcs_pkg::REG_MAX_DUTY_CH2: cfg.max_duty[2] <= cfg_data[mpcs_pkg::MAXD_W-1:0];
        mpcs_pkg::REG_DEADBAND_CH0: cfg.deadband[0] <= cfg_data;
        mpcs_pkg::REG_DEADBAND_CH1: cfg.deadband[1] <= cfg_data;
        mpcs_pkg::REG_DEADBAND_CH2: cfg.deadband[2] <= cfg_data;
        mpcs_pkg::REG_FORWARD_SIGN_MASK: begin
          cfg.forward_sign_mask <= cfg_data[mpcs_pkg::NUM_CH_REGS-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  mpcs_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .channel        (channel),
    .command        (command),
    .at_lower_limit (at_lower_limit),
    .at_upper_limit (at_upper_limit),
    .cfg            (cfg),
    .q              (s1)
  );

  mpcs_deadband u_deadband (
    .clk (clk),
    .rst (rst),
    .d   (s1),
    .q   (s2)
  );

  mpcs_clamp #(
    .FULL_DUTY(FULL_DUTY),
    .MIN_DUTY (MIN_DUTY)
  ) u_clamp (
    .clk              (clk),
    .rst              (rst),
    .d                (s2),
    .done             (done),
    .out_channel      (out_channel),
    .duty             (duty),
    .direction        (direction),
    .reported_command (reported_command)
  );

endmodule

// ===== sv/mpcs_checker.sv =====
// Port-level checker for the motor PWM command shaper and its bind.
module mpcs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [1:0]                        channel,
  input logic signed [mpcs_pkg::CMD_W-1:0] command,
  input logic                              done,
  input logic [1:0]                        out_channel,
  input logic                              direction,
  input logic signed [mpcs_pkg::CMD_W-1:0] reported_command
);

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted word produced no result after three cycles");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching accepted word");

  a_channel: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_channel == $past(channel, 3)))
    else $error("result channel does not match the accepted word");

  a_direction: assert property (@(posedge clk) disable iff (rst)
    done |-> (direction == ($past(command, 3) <= 0)))
    else $error("direction does not follow the command sign");

  a_rep_sign: assert property (@(posedge clk) disable iff (rst)
    (done && !direction) |-> !reported_command[mpcs_pkg::CMD_W-1])
    else $error("forward command reported as negative");

endmodule

bind motor_pwm_command_shaper mpcs_checker u_mpcs_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .channel          (channel),
  .command          (command),
  .done             (done),
  .out_channel      (out_channel),
  .direction        (direction),
  .reported_command (reported_command)
);
